// ===== rtl/core/fesg_pkg.sv =====
// ----------------------------------------------------------------------------
// fesg_pkg: shared types and constants of the filled ellipse span generator
// Widths of the datapath, reset values of the canvas registers, register
// indexes and the span record handed from the clipper to the output stage.
// ----------------------------------------------------------------------------
package fesg_pkg;

    localparam logic [5:0] MAX_VERT_RADIUS = 6'd63;
    localparam logic [8:0] MAX_CANVAS_DIM  = 9'd256;

    localparam logic [8:0] CANVAS_WIDTH_RESET  = 9'd128;
    localparam logic [8:0] CANVAS_HEIGHT_RESET = 9'd160;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_BITS = 18;
    localparam int MUL_B_BITS = 16;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    typedef struct packed {
        logic [7:0]  x_left;
        logic [7:0]  x_right;
        logic        span_visible;
        logic [7:0]  y_upper;
        logic        upper_visible;
        logic [7:0]  y_lower;
        logic        lower_visible;
        logic [15:0] fill_color;
        logic        last_span;
    } span_t;

endpackage

// ===== rtl/core/fesg_mul.sv =====
// ----------------------------------------------------------------------------
// fesg_mul: shared unsigned multiplier
// One registered product per cycle; the sequencer time-shares it for every
// square and cross product of the ellipse equation.
// ----------------------------------------------------------------------------
module fesg_mul (
    input  logic                          aclk,
    input  logic [fesg_pkg::MUL_A_BITS-1:0] op_a,
    input  logic [fesg_pkg::MUL_B_BITS-1:0] op_b,
    output logic [fesg_pkg::MUL_P_BITS-1:0] prod
);
    import fesg_pkg::*;

    logic [MUL_P_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_BITS'(op_a) * MUL_P_BITS'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/fesg_clip.sv =====
// ----------------------------------------------------------------------------
// fesg_clip: span clipper
// Turns a center, half-width and row offset into a canvas-clipped span pair
// with its visibility flags.
// ----------------------------------------------------------------------------
module fesg_clip (
    input  logic signed [9:0]  center_x,
    input  logic signed [9:0]  center_y,
    input  logic [7:0]         half_width,
    input  logic [5:0]         row_offset,
    input  logic [8:0]         canvas_width,
    input  logic [8:0]         canvas_height,
    input  logic [15:0]        color,
    input  logic               last,
    output fesg_pkg::span_t    span
);
    import fesg_pkg::*;

    logic [8:0]         cw;
    logic [8:0]         ch;
    logic signed [11:0] cx_e;
    logic signed [11:0] cy_e;
    logic signed [11:0] half_e;
    logic signed [11:0] k_e;
    logic signed [11:0] cw_e;
    logic signed [11:0] ch_e;
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    logic signed [11:0] lo_c;
    logic signed [11:0] hi_c;
    logic signed [11:0] yu;
    logic signed [11:0] yl;
    logic               sv;
    logic               uv;
    logic               lv;

    always_comb begin
        cw     = (canvas_width  > MAX_CANVAS_DIM) ? MAX_CANVAS_DIM : canvas_width;
        ch     = (canvas_height > MAX_CANVAS_DIM) ? MAX_CANVAS_DIM : canvas_height;
        cx_e   = {{2{center_x[9]}}, center_x};
        cy_e   = {{2{center_y[9]}}, center_y};
        half_e = {4'b0, half_width};
        k_e    = {6'b0, row_offset};
        cw_e   = {3'b0, cw};
        ch_e   = {3'b0, ch};

        lo   = cx_e - half_e;
        hi   = cx_e + half_e;
        lo_c = (lo < 12'sd0) ? 12'sd0 : lo;
        hi_c = (hi >= cw_e) ? (cw_e - 12'sd1) : hi;
        sv   = (cw != 9'd0) && (lo_c <= hi_c);

        yu = cy_e - k_e;
        yl = cy_e + k_e;
        uv = (yu >= 12'sd0) && (yu < ch_e);
        lv = (row_offset != 6'd0) && (yl >= 12'sd0) && (yl < ch_e);

        span.x_left        = sv ? lo_c[7:0] : 8'd0;
        span.x_right       = sv ? hi_c[7:0] : 8'd0;
        span.span_visible  = sv;
        span.y_upper       = uv ? yu[7:0] : 8'd0;
        span.upper_visible = uv;
        span.y_lower       = lv ? yl[7:0] : 8'd0;
        span.lower_visible = lv;
        span.fill_color    = color;
        span.last_span     = last;
    end

endmodule

// ===== rtl/core/filled_ellipse_span_generator_core.sv =====
// ----------------------------------------------------------------------------
// filled_ellipse_span_generator_core: filled ellipse span generator
// Each input beat is one ellipse; the block answers with h+1 span beats, one
// per row offset k = 0..h, each covering rows center_y-k and center_y+k and
// clipped to the canvas. The last beat carries last_span. One ellipse
// occupies the block through setup states S_SQ_H, S_SQ_W, S_HHWW, S_BASE
// and one S_EMIT per span beat, which waits while the output register is
// busy. Each row k >= 1 adds S_KK, S_KKWW, S_RHS and, per test of the
// half-width search (its decrements plus one), S_TEST, S_SQ_X, S_CMP; a
// test that finds the candidate already at zero passes S_TEST alone. All
// squares and cross products pass through the single multiplier, which sets
// this order. s_ready is low for the whole time. An output register holds
// the current span beat, so a new ellipse is taken while the last span still
// waits. The always-ready cfg channel writes the canvas registers.
// ----------------------------------------------------------------------------
module filled_ellipse_span_generator_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fesg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [8:0]                          cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [9:0]                   s_center_x,
    input  logic signed [9:0]                   s_center_y,
    input  logic [7:0]                          s_horizontal_radius,
    input  logic [5:0]                          s_vertical_radius,
    input  logic [15:0]                         s_color,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_x_left,
    output logic [7:0]                          m_x_right,
    output logic                                m_span_visible,
    output logic [7:0]                          m_y_upper,
    output logic                                m_upper_visible,
    output logic [7:0]                          m_y_lower,
    output logic                                m_lower_visible,
    output logic [15:0]                         m_fill_color,
    output logic                                m_last_span
);
    import fesg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_H,
        S_SQ_W,
        S_HHWW,
        S_BASE,
        S_EMIT,
        S_KK,
        S_KKWW,
        S_RHS,
        S_TEST,
        S_SQ_X,
        S_CMP
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         cw_reg, cw_next;
    logic [8:0]         ch_reg, ch_next;
    logic signed [9:0]  cx_reg, cx_next;
    logic signed [9:0]  cy_reg, cy_next;
    logic [7:0]         w_reg, w_next;
    logic [5:0]         h_reg, h_next;
    logic [15:0]        color_reg, color_next;
    logic [11:0]        hh_reg, hh_next;
    logic [15:0]        ww_reg, ww_next;
    logic [27:0]        hhww_reg, hhww_next;
    logic [27:0]        rhs_reg, rhs_next;
    logic [5:0]         k_reg, k_next;
    logic [8:0]         x1_reg, x1_next;
    logic [7:0]         x0_reg, x0_next;
    logic signed [8:0]  step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    span_t              span_reg, span_next;

    logic [MUL_A_BITS-1:0] op_a;
    logic [MUL_B_BITS-1:0] op_b;
    logic [MUL_P_BITS-1:0] prod;
    span_t                 span_c;
    logic                  last_row;
    logic                  out_free;
    logic signed [10:0]    start_s;
    logic signed [9:0]     step_d;

    fesg_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    fesg_clip u_clip (
        .center_x      (cx_reg),
        .center_y      (cy_reg),
        .half_width    (x0_reg),
        .row_offset    (k_reg),
        .canvas_width  (cw_reg),
        .canvas_height (ch_reg),
        .color         (color_reg),
        .last          (last_row),
        .span          (span_c)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign last_row  = (k_reg == h_reg);
    assign out_free  = !m_valid_reg || m_ready;

    // Search start for the next row: previous half-width minus previous step
    // plus one, never below zero.
    assign start_s = $signed({3'b0, x0_reg}) - $signed({{2{step_reg[8]}}, step_reg})
                     + 11'sd1;
    assign step_d  = $signed({2'b0, x0_reg}) - $signed({1'b0, x1_reg});

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_SQ_H: begin
                op_a = MUL_A_BITS'(h_reg);
                op_b = MUL_B_BITS'(h_reg);
            end
            S_SQ_W: begin
                op_a = MUL_A_BITS'(w_reg);
                op_b = MUL_B_BITS'(w_reg);
            end
            S_HHWW: begin
                op_a = MUL_A_BITS'(hh_reg);
                op_b = prod[15:0];
            end
            S_KK: begin
                op_a = MUL_A_BITS'(k_reg);
                op_b = MUL_B_BITS'(k_reg);
            end
            S_KKWW: begin
                op_a = MUL_A_BITS'(prod[11:0]);
                op_b = ww_reg;
            end
            S_TEST: begin
                op_a = MUL_A_BITS'(x1_reg);
                op_b = MUL_B_BITS'(x1_reg);
            end
            S_SQ_X: begin
                op_a = prod[17:0];
                op_b = MUL_B_BITS'(hh_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cw_next      = cw_reg;
        ch_next      = ch_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        color_next   = color_reg;
        hh_next      = hh_reg;
        ww_next      = ww_reg;
        hhww_next    = hhww_reg;
        rhs_next     = rhs_reg;
        k_next       = k_reg;
        x1_next      = x1_reg;
        x0_next      = x0_reg;
        step_next    = step_reg;
        span_next    = span_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  cw_next = cfg_data;
                CFG_CANVAS_HEIGHT: ch_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cx_next    = s_center_x;
                    cy_next    = s_center_y;
                    w_next     = s_horizontal_radius;
                    h_next     = (s_vertical_radius > MAX_VERT_RADIUS) ?
                                 MAX_VERT_RADIUS : s_vertical_radius;
                    color_next = s_color;
                    k_next     = 6'd0;
                    x0_next    = s_horizontal_radius;
                    step_next  = 9'sd0;
                    state_next = S_SQ_H;
                end
            end
            S_SQ_H: state_next = S_SQ_W;
            S_SQ_W: begin
                hh_next    = prod[11:0];
                state_next = S_HHWW;
            end
            S_HHWW: begin
                ww_next    = prod[15:0];
                state_next = S_BASE;
            end
            S_BASE: begin
                hhww_next  = prod[27:0];
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    span_next    = span_c;
                    m_valid_next = 1'b1;
                    if (last_row) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 6'd1;
                        x1_next    = start_s[10] ? 9'd0 : start_s[8:0];
                        state_next = S_KK;
                    end
                end
            end
            S_KK:   state_next = S_KKWW;
            S_KKWW: state_next = S_RHS;
            S_RHS: begin
                // k never exceeds h, so this never goes negative.
                rhs_next   = hhww_reg - prod[27:0];
                state_next = S_TEST;
            end
            S_TEST: begin
                if (x1_reg == 9'd0) begin
                    step_next  = step_d[8:0];
                    x0_next    = x1_reg[7:0];
                    state_next = S_EMIT;
                end else begin
                    state_next = S_SQ_X;
                end
            end
            S_SQ_X: state_next = S_CMP;
            S_CMP: begin
                if (prod > MUL_P_BITS'(rhs_reg)) begin
                    x1_next    = x1_reg - 9'd1;
                    state_next = S_TEST;
                end else begin
                    // A point inside the ellipse is never wider than w.
                    step_next  = step_d[8:0];
                    x0_next    = x1_reg[7:0];
                    state_next = S_EMIT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cw_reg      <= CANVAS_WIDTH_RESET;
            ch_reg      <= CANVAS_HEIGHT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cw_reg      <= cw_next;
            ch_reg      <= ch_next;
        end
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        color_reg <= color_next;
        hh_reg    <= hh_next;
        ww_reg    <= ww_next;
        hhww_reg  <= hhww_next;
        rhs_reg   <= rhs_next;
        k_reg     <= k_next;
        x1_reg    <= x1_next;
        x0_reg    <= x0_next;
        step_reg  <= step_next;
        span_reg  <= span_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_x_left        = span_reg.x_left;
    assign m_x_right       = span_reg.x_right;
    assign m_span_visible  = span_reg.span_visible;
    assign m_y_upper       = span_reg.y_upper;
    assign m_upper_visible = span_reg.upper_visible;
    assign m_y_lower       = span_reg.y_lower;
    assign m_lower_visible = span_reg.lower_visible;
    assign m_fill_color    = span_reg.fill_color;
    assign m_last_span     = span_reg.last_span;

endmodule
